// File: design/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types and constants for the rectangle polygon clipper.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int COORD_BITS = 16;
    localparam int NUM_STAGES = 4;
    localparam int MAX_RES    = 18;
    localparam int PROD_BITS  = 2 * COORD_BITS;
    localparam int CNT_BITS   = $clog2(PROD_BITS);
    localparam int RES_BITS   = $clog2(MAX_RES + 1);
    localparam int CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_XMIN  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_XMAX  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_YMIN  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_YMAX  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORDER = 3'd4;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef enum logic [1:0] {
        K_VTX,
        K_END,
        K_CLOSE
    } t_kind;

    typedef enum logic [1:0] {
        E_LEFT,
        E_RIGHT,
        E_BOTTOM,
        E_TOP
    } t_edge;

    typedef struct packed {
        t_kind  kind;
        t_coord x;
        t_coord y;
    } t_tok;

    typedef struct packed {
        t_coord xmin;
        t_coord xmax;
        t_coord ymin;
        t_coord ymax;
    } t_rect;

endpackage

// File: design/prc_in_if.sv
// ----------------------------------------------------------------------------
// prc_in_if
// Vertex input channel: one polygon vertex per beat.
// ----------------------------------------------------------------------------
interface prc_in_if;
    logic            valid;
    logic            ready;
    prc_pkg::t_coord vertex_x;
    prc_pkg::t_coord vertex_y;
    logic            is_last_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output is_last_vertex,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input is_last_vertex,
                    output ready);
endinterface

// File: design/prc_out_if.sv
// ----------------------------------------------------------------------------
// prc_out_if
// Clipped vertex output channel: one result per beat.
// ----------------------------------------------------------------------------
interface prc_out_if;
    logic            valid;
    logic            ready;
    prc_pkg::t_coord out_x;
    prc_pkg::t_coord out_y;
    logic            end_of_polygon;
    logic            no_vertex;

    modport source (output valid, output out_x, output out_y, output end_of_polygon,
                    output no_vertex, input ready);
    modport sink   (input valid, input out_x, input out_y, input end_of_polygon,
                    input no_vertex, output ready);
endinterface

// File: design/prc_cell.sv
// ----------------------------------------------------------------------------
// prc_cell
// One clip edge stage: keeps first/previous vertex, emits clipped vertices,
// crossing points via a serial restoring divider.
// ----------------------------------------------------------------------------
module prc_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  prc_pkg::t_rect  i_rect,
    input  logic [1:0]      i_edge,
    input  logic            i_valid,
    output logic            o_ready,
    input  prc_pkg::t_tok   i_tok,
    output logic            o_valid,
    input  logic            i_ready,
    output prc_pkg::t_tok   o_tok
);

    localparam int CW = prc_pkg::COORD_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_RND,
        S_EMIT_C,
        S_EMIT_B,
        S_FWD
    } t_state;

    t_state                      r_state;
    logic                        r_started;
    prc_pkg::t_coord             r_fx, r_fy, r_px, r_py;
    prc_pkg::t_coord             r_ax, r_ay, r_bx, r_by;
    logic                        r_fwd;
    prc_pkg::t_kind              r_fwd_kind;
    logic                        r_emit_c, r_emit_b;
    logic                        r_neg, r_zero, r_vert;
    logic [CW-1:0]               r_md, r_mk, r_d;
    logic [prc_pkg::PROD_BITS-1:0] r_prod;
    logic [CW-1:0]               r_rem;
    logic [CW:0]                 r_q;
    logic [prc_pkg::CNT_BITS-1:0] r_cnt;
    prc_pkg::t_coord             r_w1, r_e;
    prc_pkg::t_coord             r_cx, r_cy;
    logic                        r_ov;
    prc_pkg::t_tok               r_otok;

    prc_pkg::t_edge  edge_sel;
    prc_pkg::t_coord e_val, ua, wa, ub, wb;
    logic            vert, ia, ib, out_free, b_off_line, emit_now;
    logic signed [CW:0] den, dw, kk, den_m, dw_m, kk_m;
    logic [CW:0]     r2, twor;
    logic            ge, rup;
    logic [CW-1:0]   rem_n;
    logic [CW:0]     off;
    logic [CW:0]     w_sum;

    always_comb begin
        edge_sel = prc_pkg::t_edge'(i_edge);
        case (edge_sel)
            prc_pkg::E_LEFT: begin
                e_val = i_rect.xmin;
                ia    = r_ax >= i_rect.xmin;
                ib    = r_bx >= i_rect.xmin;
            end
            prc_pkg::E_RIGHT: begin
                e_val = i_rect.xmax;
                ia    = r_ax <= i_rect.xmax;
                ib    = r_bx <= i_rect.xmax;
            end
            prc_pkg::E_BOTTOM: begin
                e_val = i_rect.ymin;
                ia    = r_ay >= i_rect.ymin;
                ib    = r_by >= i_rect.ymin;
            end
            default: begin
                e_val = i_rect.ymax;
                ia    = r_ay <= i_rect.ymax;
                ib    = r_by <= i_rect.ymax;
            end
        endcase
        vert = (edge_sel == prc_pkg::E_LEFT) || (edge_sel == prc_pkg::E_RIGHT);
        ua   = vert ? r_ax : r_ay;
        wa   = vert ? r_ay : r_ax;
        ub   = vert ? r_bx : r_by;
        wb   = vert ? r_by : r_bx;
        b_off_line = (ub != e_val);
        den  = {ub[CW-1], ub} - {ua[CW-1], ua};
        dw   = {wb[CW-1], wb} - {wa[CW-1], wa};
        kk   = {e_val[CW-1], e_val} - {ua[CW-1], ua};
        den_m = den[CW] ? -den : den;
        dw_m  = dw[CW]  ? -dw  : dw;
        kk_m  = kk[CW]  ? -kk  : kk;

        r2    = {r_rem, r_prod[prc_pkg::PROD_BITS-1]};
        ge    = r2 >= {1'b0, r_d};
        rem_n = ge ? CW'(r2 - {1'b0, r_d}) : r2[CW-1:0];

        twor  = {r_rem, 1'b0};
        rup   = r_neg ? (twor > {1'b0, r_d}) : (twor >= {1'b0, r_d});
        off   = r_zero ? '0 : (r_q + {{CW{1'b0}}, rup});
        w_sum = r_neg ? ({r_w1[CW-1], r_w1} - off) : ({r_w1[CW-1], r_w1} + off);

        out_free = !r_ov || i_ready;
        emit_now = out_free && ((r_state == S_EMIT_C) || (r_state == S_EMIT_B) ||
                                (r_state == S_FWD));
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ov;
    assign o_tok   = r_otok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_started <= 1'b0;
            r_fwd     <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (r_ov && i_ready && !emit_now) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        case (i_tok.kind)
                            prc_pkg::K_VTX: begin
                                r_px <= i_tok.x;
                                r_py <= i_tok.y;
                                if (!r_started) begin
                                    r_started <= 1'b1;
                                    r_fx      <= i_tok.x;
                                    r_fy      <= i_tok.y;
                                end else begin
                                    r_ax    <= r_px;
                                    r_ay    <= r_py;
                                    r_bx    <= i_tok.x;
                                    r_by    <= i_tok.y;
                                    r_fwd   <= 1'b0;
                                    r_state <= S_EVAL;
                                end
                            end
                            prc_pkg::K_CLOSE: begin
                                r_fwd      <= 1'b1;
                                r_fwd_kind <= prc_pkg::K_CLOSE;
                                r_started  <= 1'b0;
                                if (r_started) begin
                                    r_ax    <= r_px;
                                    r_ay    <= r_py;
                                    r_bx    <= r_fx;
                                    r_by    <= r_fy;
                                    r_state <= S_EVAL;
                                end else begin
                                    r_state <= S_FWD;
                                end
                            end
                            default: begin
                                r_fwd      <= 1'b1;
                                r_fwd_kind <= prc_pkg::K_END;
                                r_state    <= S_FWD;
                            end
                        endcase
                    end
                end
                S_EVAL: begin
                    if (!ia && !ib) begin
                        r_state <= r_fwd ? S_FWD : S_IDLE;
                    end else if (ia && ib) begin
                        r_state <= S_EMIT_B;
                    end else begin
                        r_emit_c <= ia || b_off_line;
                        r_emit_b <= !ia;
                        r_md     <= dw_m[CW-1:0];
                        r_mk     <= kk_m[CW-1:0];
                        r_d      <= den_m[CW-1:0];
                        r_neg    <= (dw[CW] != kk[CW]) != den[CW];
                        r_zero   <= (den == '0) || (dw == '0) || (kk == '0);
                        r_vert   <= vert;
                        r_e      <= e_val;
                        r_w1     <= wa;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_md * r_mk;
                    r_rem   <= '0;
                    r_q     <= '0;
                    r_cnt   <= prc_pkg::CNT_BITS'(prc_pkg::PROD_BITS - 1);
                    r_state <= r_zero ? S_RND : S_DIV;
                end
                S_DIV: begin
                    r_prod <= r_prod << 1;
                    r_rem  <= rem_n;
                    r_q    <= {r_q[CW-1:0], ge};
                    r_cnt  <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_state <= S_RND;
                end
                S_RND: begin
                    r_cx    <= r_vert ? r_e : w_sum[CW-1:0];
                    r_cy    <= r_vert ? w_sum[CW-1:0] : r_e;
                    r_state <= r_emit_c ? S_EMIT_C : S_EMIT_B;
                end
                S_EMIT_C: begin
                    if (out_free) begin
                        r_ov        <= 1'b1;
                        r_otok.kind <= prc_pkg::K_VTX;
                        r_otok.x    <= r_cx;
                        r_otok.y    <= r_cy;
                        if (r_emit_b) r_state <= S_EMIT_B;
                        else          r_state <= r_fwd ? S_FWD : S_IDLE;
                    end
                end
                S_EMIT_B: begin
                    if (out_free) begin
                        r_ov        <= 1'b1;
                        r_otok.kind <= prc_pkg::K_VTX;
                        r_otok.x    <= r_bx;
                        r_otok.y    <= r_by;
                        r_state     <= r_fwd ? S_FWD : S_IDLE;
                    end
                end
                S_FWD: begin
                    if (out_free) begin
                        r_ov        <= 1'b1;
                        r_otok.kind <= r_fwd_kind;
                        r_otok.x    <= '0;
                        r_otok.y    <= '0;
                        r_fwd       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: design/prc_collect.sv
// ----------------------------------------------------------------------------
// prc_collect
// Result stage: caps results per input vertex, tags the polygon end and
// emits the empty-polygon marker.
// ----------------------------------------------------------------------------
module prc_collect (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  prc_pkg::t_tok i_tok,
    prc_out_if.source     o_out
);

    logic [prc_pkg::RES_BITS-1:0] r_cnt;
    logic                         r_pend;
    prc_pkg::t_coord              r_px, r_py;
    logic                         r_ov;
    prc_pkg::t_coord              r_ox, r_oy;
    logic                         r_eop, r_nov;
    logic                         out_free;
    logic                         emit_now;

    assign out_free             = !r_ov || o_out.ready;
    assign o_ready              = out_free;
    assign o_out.valid          = r_ov;
    assign o_out.out_x          = r_ox;
    assign o_out.out_y          = r_oy;
    assign o_out.end_of_polygon = r_eop;
    assign o_out.no_vertex      = r_nov;

    always_comb begin
        case (i_tok.kind)
            prc_pkg::K_VTX:
                emit_now = r_pend && (r_cnt != prc_pkg::RES_BITS'(prc_pkg::MAX_RES));
            prc_pkg::K_CLOSE:
                emit_now = 1'b1;
            default:
                emit_now = r_pend;
        endcase
        emit_now = emit_now && i_valid && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (r_ov && o_out.ready && !emit_now) r_ov <= 1'b0;
            if (i_valid && out_free) begin
                case (i_tok.kind)
                    prc_pkg::K_VTX: begin
                        if (r_cnt != prc_pkg::RES_BITS'(prc_pkg::MAX_RES)) begin
                            if (r_pend) begin
                                r_ov  <= 1'b1;
                                r_ox  <= r_px;
                                r_oy  <= r_py;
                                r_eop <= 1'b0;
                                r_nov <= 1'b0;
                            end
                            r_pend <= 1'b1;
                            r_px   <= i_tok.x;
                            r_py   <= i_tok.y;
                            r_cnt  <= r_cnt + 1'b1;
                        end
                    end
                    prc_pkg::K_CLOSE: begin
                        r_ov   <= 1'b1;
                        r_ox   <= r_pend ? r_px : '0;
                        r_oy   <= r_pend ? r_py : '0;
                        r_eop  <= 1'b1;
                        r_nov  <= !r_pend;
                        r_pend <= 1'b0;
                        r_cnt  <= '0;
                    end
                    default: begin
                        if (r_pend) begin
                            r_ov  <= 1'b1;
                            r_ox  <= r_px;
                            r_oy  <= r_py;
                            r_eop <= 1'b0;
                            r_nov <= 1'b0;
                        end
                        r_pend <= 1'b0;
                        r_cnt  <= '0;
                    end
                endcase
            end
        end
    end

endmodule

// File: design/polygon_rect_clipper.sv
// ----------------------------------------------------------------------------
// polygon_rect_clipper
// Sutherland-Hodgman clipper against an axis-aligned rectangle, a chain
// of NUM_STAGES edge cells with configurable edge order.
// ----------------------------------------------------------------------------
// Cell path: an edge fully inside goes from evaluation to emit; one with a
// crossing also passes multiply, divide (if no term is zero) and rounding.
// The result stage holds each vertex until the next token arrives.
// Input: one vertex at a time; the next is taken once the first cell has
// accepted the vertex and its end or close token.
// Reset: synchronous, active low; rectangle opens to full range, order 228,
// all cells forget their polygon. No clearing pass.
module polygon_rect_clipper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [prc_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [prc_pkg::COORD_BITS-1:0]      i_cfg_data,
    prc_in_if.sink                              i_in,
    prc_out_if.source                           o_out
);

    localparam int NS = prc_pkg::NUM_STAGES;

    typedef enum logic [1:0] {
        I_IDLE,
        I_VTX,
        I_TAIL
    } t_inj;

    t_inj            r_inj;
    prc_pkg::t_coord r_vx, r_vy;
    logic            r_last;
    prc_pkg::t_rect  r_rect;
    logic [7:0]      r_order;

    logic            c_valid [NS+1];
    logic            c_ready [NS+1];
    prc_pkg::t_tok   c_tok   [NS+1];

    assign i_in.ready = (r_inj == I_IDLE);

    always_comb begin
        c_valid[0]    = (r_inj != I_IDLE);
        c_tok[0].x    = r_vx;
        c_tok[0].y    = r_vy;
        if (r_inj == I_VTX) c_tok[0].kind = prc_pkg::K_VTX;
        else                c_tok[0].kind = r_last ? prc_pkg::K_CLOSE : prc_pkg::K_END;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj       <= I_IDLE;
            r_rect.xmin <= {1'b1, {(prc_pkg::COORD_BITS-1){1'b0}}};
            r_rect.xmax <= {1'b0, {(prc_pkg::COORD_BITS-1){1'b1}}};
            r_rect.ymin <= {1'b1, {(prc_pkg::COORD_BITS-1){1'b0}}};
            r_rect.ymax <= {1'b0, {(prc_pkg::COORD_BITS-1){1'b1}}};
            r_order     <= 8'd228;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    prc_pkg::CFG_XMIN:  r_rect.xmin <= i_cfg_data;
                    prc_pkg::CFG_XMAX:  r_rect.xmax <= i_cfg_data;
                    prc_pkg::CFG_YMIN:  r_rect.ymin <= i_cfg_data;
                    prc_pkg::CFG_YMAX:  r_rect.ymax <= i_cfg_data;
                    prc_pkg::CFG_ORDER: r_order     <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            case (r_inj)
                I_IDLE: begin
                    if (i_in.valid) begin
                        r_vx   <= i_in.vertex_x;
                        r_vy   <= i_in.vertex_y;
                        r_last <= i_in.is_last_vertex;
                        r_inj  <= I_VTX;
                    end
                end
                I_VTX: begin
                    if (c_ready[0]) r_inj <= I_TAIL;
                end
                I_TAIL: begin
                    if (c_ready[0]) r_inj <= I_IDLE;
                end
                default: r_inj <= I_IDLE;
            endcase
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_cell
        prc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_rect  (r_rect),
            .i_edge  (r_order[2*s +: 2]),
            .i_valid (c_valid[s]),
            .o_ready (c_ready[s]),
            .i_tok   (c_tok[s]),
            .o_valid (c_valid[s+1]),
            .i_ready (c_ready[s+1]),
            .o_tok   (c_tok[s+1])
        );
    end

    prc_collect u_collect (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[NS]),
        .o_ready (c_ready[NS]),
        .i_tok   (c_tok[NS]),
        .o_out   (o_out)
    );

endmodule

// File: sim/prc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prc_checker
// Watches the vertex, result and register ports of the polygon clipper,
// predicts the clipped vertex stream of each accepted beat and compares every
// result beat with the oldest expected one.
// ----------------------------------------------------------------------------
module prc_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [prc_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [prc_pkg::COORD_BITS-1:0]   i_cfg_data,
    prc_in_if                                i_in,
    prc_out_if                               i_out,
    output int                               o_errors,
    output int                               o_pending
);

    typedef struct {
        int x;
        int y;
    } t_pt;

    typedef struct {
        prc_pkg::t_coord x;
        prc_pkg::t_coord y;
        logic            eop;
        logic            nv;
    } t_res;

    int     xmin, xmax, ymin, ymax;
    logic [7:0] order;
    int     first_x [prc_pkg::NUM_STAGES];
    int     first_y [prc_pkg::NUM_STAGES];
    int     prev_x  [prc_pkg::NUM_STAGES];
    int     prev_y  [prc_pkg::NUM_STAGES];
    bit     started [prc_pkg::NUM_STAGES];
    t_res   expected_q [$];

    function automatic bit is_in(prc_pkg::t_edge e, int x, int y);
        case (e)
            prc_pkg::E_LEFT:   return x >= xmin;
            prc_pkg::E_RIGHT:  return x <= xmax;
            prc_pkg::E_BOTTOM: return y >= ymin;
            default:           return y <= ymax;
        endcase
    endfunction

    // point along the boundary u = b, rounded to nearest, ties toward +inf
    function automatic int crossing(int b, int u1, int w1, int u2, int w2);
        longint den, dw, k, p, q, r;
        bit     neg;
        den = u2 - u1;
        dw  = w2 - w1;
        k   = b - u1;
        if (den == 0 || dw == 0 || k == 0) return w1;
        neg = ((dw < 0) != (k < 0)) != (den < 0);
        p = (dw < 0 ? -dw : dw) * (k < 0 ? -k : k);
        if (den < 0) den = -den;
        q = p / den;
        r = p % den;
        if (neg ? (2 * r > den) : (2 * r >= den)) q++;
        return neg ? w1 - int'(q) : w1 + int'(q);
    endfunction

    task automatic clip_edge(prc_pkg::t_edge e, int ax, int ay, int bx, int by,
                             ref t_pt q[$]);
        bit ia, ib, vert;
        int b, cx, cy;
        ia   = is_in(e, ax, ay);
        ib   = is_in(e, bx, by);
        vert = (e == prc_pkg::E_LEFT || e == prc_pkg::E_RIGHT);
        b    = (e == prc_pkg::E_LEFT) ? xmin : (e == prc_pkg::E_RIGHT) ? xmax :
               (e == prc_pkg::E_BOTTOM) ? ymin : ymax;
        if (!ia && !ib) return;
        if (ia && ib) begin
            q.insert(q.size(), t_pt'{bx, by});
            return;
        end
        if (vert) begin
            cx = b;
            cy = crossing(b, ax, ay, bx, by);
        end else begin
            cy = b;
            cx = crossing(b, ay, ax, by, bx);
        end
        if (ia) begin
            q.insert(q.size(), t_pt'{cx, cy});
            return;
        end
        // entering exactly on the boundary gives the endpoint only
        if ((vert ? bx : by) != b) q.insert(q.size(), t_pt'{cx, cy});
        q.insert(q.size(), t_pt'{bx, by});
    endtask

    task automatic predict_vertex(int vx, int vy, bit last);
        t_pt            cur [$];
        t_pt            nxt [$];
        prc_pkg::t_edge e;
        int             n;
        cur.insert(0, t_pt'{vx, vy});
        for (int s = 0; s < prc_pkg::NUM_STAGES; s++) begin
            e = prc_pkg::t_edge'(order[2*s +: 2]);
            nxt.delete();
            foreach (cur[i]) begin
                if (!started[s]) begin
                    started[s] = 1'b1;
                    first_x[s] = cur[i].x;
                    first_y[s] = cur[i].y;
                end else begin
                    clip_edge(e, prev_x[s], prev_y[s], cur[i].x, cur[i].y, nxt);
                end
                prev_x[s] = cur[i].x;
                prev_y[s] = cur[i].y;
            end
            if (last) begin
                if (started[s]) clip_edge(e, prev_x[s], prev_y[s], first_x[s], first_y[s], nxt);
                started[s] = 1'b0;
            end
            cur = nxt;
        end
        n = (cur.size() > prc_pkg::MAX_RES) ? prc_pkg::MAX_RES : cur.size();
        for (int i = 0; i < n; i++)
            expected_q.insert(expected_q.size(),
                              t_res'{prc_pkg::t_coord'(cur[i].x), prc_pkg::t_coord'(cur[i].y),
                                     last && (i == n - 1), 1'b0});
        if (last && n == 0)
            expected_q.insert(expected_q.size(), t_res'{'0, '0, 1'b1, 1'b1});
    endtask

    always @(posedge i_clk) begin
        t_res r;
        if (!i_rst_n) begin
            xmin  = -32768;
            xmax  = 32767;
            ymin  = -32768;
            ymax  = 32767;
            order = 8'd228;
            for (int s = 0; s < prc_pkg::NUM_STAGES; s++) begin
                first_x[s] = 0;
                first_y[s] = 0;
                prev_x[s]  = 0;
                prev_y[s]  = 0;
                started[s] = 1'b0;
            end
            expected_q.delete();
            o_errors  = 0;
            o_pending = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected beat x=%0d y=%0d eop=%b nv=%b", $time,
                             i_out.out_x, i_out.out_y, i_out.end_of_polygon, i_out.no_vertex);
                    o_errors++;
                end else begin
                    r = expected_q.pop_front();
                    if (r.x !== i_out.out_x || r.y !== i_out.out_y ||
                        r.eop !== i_out.end_of_polygon || r.nv !== i_out.no_vertex) begin
                        $display("%0t: mismatch exp x=%0d y=%0d eop=%b nv=%b", $time,
                                 r.x, r.y, r.eop, r.nv);
                        $display("%0t:          act x=%0d y=%0d eop=%b nv=%b", $time,
                                 i_out.out_x, i_out.out_y, i_out.end_of_polygon,
                                 i_out.no_vertex);
                        o_errors++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    prc_pkg::CFG_XMIN:  xmin  = int'(signed'(i_cfg_data));
                    prc_pkg::CFG_XMAX:  xmax  = int'(signed'(i_cfg_data));
                    prc_pkg::CFG_YMIN:  ymin  = int'(signed'(i_cfg_data));
                    prc_pkg::CFG_YMAX:  ymax  = int'(signed'(i_cfg_data));
                    prc_pkg::CFG_ORDER: order = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                predict_vertex(int'(i_in.vertex_x), int'(i_in.vertex_y), i_in.is_last_vertex);
            o_pending = expected_q.size();
        end
    end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives polygons through the rectangle clipper under a series of clip
// rectangles and edge orders, with bursty input and a stalling receiver;
// the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG = 3000;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [prc_pkg::CFG_IDX_BITS-1:0] cfg_idx = '0;
    logic [prc_pkg::COORD_BITS-1:0]   cfg_data = '0;
    int                               errors;
    int                               pending;
    int                               sent = 0;
    int                               burst_left = 0;
    int                               idle_cycles = 0;
    int                               rxmin, rxmax, rymin, rymax;

    prc_in_if  in_ch ();
    prc_out_if out_ch ();

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.vertex_x       = '0;
        in_ch.vertex_y       = '0;
        in_ch.is_last_vertex = 1'b0;
        out_ch.ready         = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    polygon_rect_clipper u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    prc_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // receiver: random ready pattern from four modes, one long hold-off mid-polygon
    always @(negedge i_clk) begin
        static int cyc = 0;
        static int mode = 0;
        static int hold = 0;
        static bit held = 1'b0;
        cyc++;
        if (cyc % 64 == 0) mode = $urandom_range(0, 3);
        if (!held && sent >= 150 && in_ch.valid && !in_ch.is_last_vertex) begin
            held = 1'b1;
            hold = 400;
        end
        if (hold > 0) begin
            hold--;
            out_ch.ready <= 1'b0;
        end else case (mode)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= $urandom_range(0, 1);
            2: out_ch.ready <= (cyc % 4 == 0);
            default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else if (i_rst_n)
            idle_cycles++;
        if (idle_cycles >= WATCHDOG) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_vertex(int x, int y, bit last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end else begin
                @(negedge i_clk);
            end
        end else begin
            @(negedge i_clk);
        end
        burst_left--;
        in_ch.valid          <= 1'b1;
        in_ch.vertex_x       <= prc_pkg::t_coord'(x);
        in_ch.vertex_y       <= prc_pkg::t_coord'(y);
        in_ch.is_last_vertex <= last;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        sent++;
    endtask

    task automatic drain;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_clip(int x0, int x1, int y0, int y1, logic [7:0] ord);
        logic [prc_pkg::COORD_BITS-1:0] vals [5];
        vals = '{x0[15:0], x1[15:0], y0[15:0], y1[15:0], {8'h00, ord}};
        rxmin = x0; rxmax = x1; rymin = y0; rymax = y1;
        for (int i = 0; i < 5; i++) begin
            @(negedge i_clk);
            cfg_we   <= 1'b1;
            cfg_idx  <= prc_pkg::CFG_IDX_BITS'(i);
            cfg_data <= vals[i];
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int near(int lo, int hi);
        int span, v;
        if ($urandom_range(0, 9) == 0) return int'($signed(16'($urandom)));
        span = (hi > lo) ? hi - lo : 64;
        if (span > 4000) span = 4000;
        v = lo - span / 2 + int'($urandom_range(0, 2 * span));
        if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1) ? lo : hi;
        return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
    endfunction

    task automatic random_polygons(int count);
        int n, cx, cy;
        for (int k = 0; k < count; k++) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 7);
            for (int i = 0; i < n; i++)
                send_vertex(near(rxmin, rxmax), near(rymin, rymax), i == n - 1);
        end
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // default full-range rectangle, extreme square
        rxmin = -32768; rxmax = 32767; rymin = -32768; rymax = 32767;
        send_vertex(-32768, -32768, 0);
        send_vertex(32767, -32768, 0);
        send_vertex(32767, 32767, 0);
        send_vertex(-32768, 32767, 1);
        drain();

        set_clip(-160, 160, -96, 96, 8'd228);
        send_vertex(0, 0, 1);
        send_vertex(500, 0, 1);
        send_vertex(-400, -300, 0);
        send_vertex(400, -300, 0);
        send_vertex(0, 400, 1);
        send_vertex(-300, 0, 0);
        send_vertex(-160, 10, 0);
        send_vertex(-300, 50, 1);
        send_vertex(1000, 1000, 0);
        send_vertex(2000, 1000, 0);
        send_vertex(1500, 3000, 1);
        send_vertex(-250, -7, 0);
        send_vertex(250, 3, 0);
        send_vertex(3, 200, 1);
        drain();

        set_clip(-160, 160, -96, 96, 8'h00);
        send_vertex(-300, 0, 0);
        send_vertex(300, 5, 0);
        send_vertex(0, 90, 1);
        drain();

        set_clip(100, -100, 50, -50, 8'h1B);
        send_vertex(0, 0, 0);
        send_vertex(10, 0, 0);
        send_vertex(0, 10, 1);
        drain();

        set_clip(-32768, 32767, -32768, 32767, 8'd228);
        random_polygons(8);
        set_clip(-800, 1200, -500, 700, 8'd228);
        random_polygons(25);
        set_clip(-3, 5, -7, 2, 8'h4E);
        random_polygons(15);
        set_clip(-32768, 0, 0, 32767, 8'hFF);
        random_polygons(12);
        set_clip(-20000, 20000, -1000, 30000, 8'h39);
        random_polygons(15);
        while (sent < 380) begin
            set_clip(int'($signed(16'($urandom))) / 2 - 1000,
                     int'($signed(16'($urandom))) / 2 + 1000,
                     int'($signed(16'($urandom))) / 2 - 1000,
                     int'($signed(16'($urandom))) / 2 + 1000,
                     8'($urandom));
            random_polygons(12);
        end

        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
design/prc_pkg.sv
design/prc_in_if.sv
design/prc_out_if.sv
design/prc_cell.sv
design/prc_collect.sv
design/polygon_rect_clipper.sv
sim/prc_checker.sv
sim/testbench.sv
